### hw/rtl/assert_macros.svh
// Assertion helpers shared by the send channel FIFO bank RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define SCFB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on every rising clock edge outside reset.
`define SCFB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define SCFB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/scfb_pkg.sv
// Shared types and constants for the send channel FIFO bank.
// No dependencies; used by the controller, the datapath and the top level.
package scfb_pkg;

    localparam int LANES        = 4;
    localparam int LANE_W       = 2;
    localparam int WORD_BITS    = 32;
    localparam int CHANNEL_BITS = 16;
    localparam int LANE_DEPTH   = 8;

    localparam int IN_TDATA_W  = ((WORD_BITS + CHANNEL_BITS + LANES + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((LANE_W + WORD_BITS + CHANNEL_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        OUT_PUSHED  = 2'd0,
        OUT_DROPPED = 2'd1,
        OUT_SENT    = 2'd2,
        OUT_NONE    = 2'd3
    } t_outcome;

    typedef enum logic {
        REQ_PUSH = 1'b0,
        REQ_FLOW = 1'b1
    } t_req_kind;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch the accepted transaction
        logic push;      // enqueue or drop, load push result
        logic none;      // load the nothing-sent result
        logic pop;       // read head of the lowest pending lane
        logic emit;      // load the popped word as a result
    } t_scfb_cmd;

    // datapath -> controller
    typedef struct packed {
        logic pend_any;  // lanes still to pop in this flow update
        logic out_free;  // output register can take a result this cycle
        logic sel_last;  // popped word in flight is the final result
    } t_scfb_status;

endpackage

### hw/rtl/scfb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module scfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/scfb_ctrl.sv
// Sequencing state machine for the send channel FIFO bank.
// Depends on scfb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module scfb_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_kind,
    output logic                  o_in_ready,
    input  scfb_pkg::t_scfb_status i_status,
    output scfb_pkg::t_scfb_cmd    o_cmd
);
    import scfb_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PUSH,
        S_PICK,
        S_READ
    } t_state;

    t_state    r_state;
    t_state    n_state;
    t_scfb_cmd cmd;
    logic      accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    cmd.capture = 1'b1;
                    n_state     = (i_in_kind == REQ_FLOW) ? S_PICK : S_PUSH;
                end
            end
            S_PUSH: begin
                if (i_status.out_free) begin
                    cmd.push = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_PICK: begin
                if (i_status.pend_any) begin
                    cmd.pop = 1'b1;
                    n_state = S_READ;
                end else if (i_status.out_free) begin
                    cmd.none = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_READ: begin
                if (i_status.out_free) begin
                    cmd.emit = 1'b1;
                    n_state  = i_status.sel_last ? S_IDLE : S_PICK;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd = cmd;

    `SCFB_ASSERT(a_cmd_onehot, i_clk, i_rst_n, $onehot0(cmd), "more than one datapath command")
    `SCFB_ASSERT_NXT(a_flow_to_pick, i_clk, i_rst_n, accept && (i_in_kind == REQ_FLOW),
        r_state == S_PICK, "flow update did not start lane scan")

endmodule

### hw/rtl/scfb_datapath.sv
// Lane pointers, occupancy, entry RAM and result register of the FIFO bank.
// Depends on scfb_pkg, scfb_ram and assert_macros.svh.
`include "assert_macros.svh"

module scfb_datapath #(
    parameter int LANE_DEPTH = scfb_pkg::LANE_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  scfb_pkg::t_scfb_cmd                 i_cmd,
    input  logic [scfb_pkg::IN_TDATA_W-1:0]     i_in_tdata,
    input  logic                                i_out_ready,
    output scfb_pkg::t_scfb_status              o_status,
    output logic                                o_out_valid,
    output scfb_pkg::t_outcome                  o_out_outcome,
    output logic [scfb_pkg::LANE_W-1:0]         o_out_lane,
    output logic [scfb_pkg::WORD_BITS-1:0]      o_out_word,
    output logic [scfb_pkg::CHANNEL_BITS-1:0]   o_out_chan,
    output logic                                o_out_last
);
    import scfb_pkg::*;

    localparam int ENTRY_W = WORD_BITS + CHANNEL_BITS;
    localparam int ENTRIES = LANES * LANE_DEPTH;
    localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int PTR_W   = (LANE_DEPTH > 1) ? $clog2(LANE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(LANE_DEPTH + 1);
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(LANE_DEPTH - 1);
    localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(LANE_DEPTH);
    localparam logic [ADDR_W-1:0] DEPTH_A  = ADDR_W'(LANE_DEPTH);

    logic [WORD_BITS-1:0]    r_word;
    logic [CHANNEL_BITS-1:0] r_chan;
    logic [LANES-1:0]        r_pend;
    logic [PTR_W-1:0]        r_head [LANES];
    logic [PTR_W-1:0]        r_tail [LANES];
    logic [CNT_W-1:0]        r_count [LANES];
    logic [LANE_W-1:0]       r_sel_lane;
    logic                    r_sel_last;

    logic                    r_out_valid;
    t_outcome                r_out_outcome;
    logic [LANE_W-1:0]       r_out_lane;
    logic [WORD_BITS-1:0]    r_out_word;
    logic [CHANNEL_BITS-1:0] r_out_chan;
    logic                    r_out_last;

    logic [LANES-1:0]        nonempty;
    logic [LANES-1:0]        pend_rest;
    logic [LANE_W-1:0]       sel;
    logic [LANE_W-1:0]       push_lane;
    logic                    push_full;
    logic                    do_write;
    logic                    out_free;
    logic                    out_load;
    logic [ADDR_W-1:0]       wr_addr;
    logic [ADDR_W-1:0]       rd_addr;
    logic [ENTRY_W-1:0]      rd_data;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            nonempty[i] = (r_count[i] != '0);
        end
    end

    // lowest pending lane wins
    always_comb begin
        sel = '0;
        for (int i = LANES - 1; i >= 0; i--) begin
            if (r_pend[i]) begin
                sel = LANE_W'(i);
            end
        end
        for (int i = 0; i < LANES; i++) begin
            pend_rest[i] = r_pend[i] && (LANE_W'(i) != sel);
        end
    end

    assign push_lane = LANE_W'(r_chan % LANES);
    assign push_full = (r_count[push_lane] == CNT_FULL);
    assign do_write  = i_cmd.push && !push_full;
    assign wr_addr   = ADDR_W'(push_lane) * DEPTH_A + ADDR_W'(r_tail[push_lane]);
    assign rd_addr   = ADDR_W'(sel) * DEPTH_A + ADDR_W'(r_head[sel]);

    assign out_free = !r_out_valid || i_out_ready;
    assign out_load = i_cmd.push || i_cmd.none || i_cmd.emit;

    scfb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_entries (
        .i_clk     (i_clk),
        .i_wr_en   (do_write),
        .i_wr_addr (wr_addr),
        .i_wr_data ({r_chan, r_word}),
        .i_rd_en   (i_cmd.pop),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // captured transaction and scan bookkeeping
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_word <= i_in_tdata[WORD_BITS-1:0];
            r_chan <= i_in_tdata[WORD_BITS +: CHANNEL_BITS];
        end
        if (i_cmd.pop) begin
            r_sel_lane <= sel;
            r_sel_last <= (pend_rest == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            for (int i = 0; i < LANES; i++) begin
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_count[i] <= '0;
            end
        end else begin
            if (i_cmd.capture) begin
                r_pend <= i_in_tdata[WORD_BITS + CHANNEL_BITS +: LANES] & nonempty;
            end else if (i_cmd.pop) begin
                r_pend <= pend_rest;
            end
            if (do_write) begin
                r_tail[push_lane]  <= (r_tail[push_lane] == PTR_LAST) ? '0
                                      : r_tail[push_lane] + 1'b1;
                r_count[push_lane] <= r_count[push_lane] + 1'b1;
            end
            if (i_cmd.pop) begin
                r_head[sel]  <= (r_head[sel] == PTR_LAST) ? '0 : r_head[sel] + 1'b1;
                r_count[sel] <= r_count[sel] - 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_outcome <= push_full ? OUT_DROPPED : OUT_PUSHED;
            r_out_lane    <= push_lane;
            r_out_word    <= '0;
            r_out_chan    <= '0;
            r_out_last    <= 1'b1;
        end else if (i_cmd.none) begin
            r_out_outcome <= OUT_NONE;
            r_out_lane    <= '0;
            r_out_word    <= '0;
            r_out_chan    <= '0;
            r_out_last    <= 1'b1;
        end else if (i_cmd.emit) begin
            r_out_outcome <= OUT_SENT;
            r_out_lane    <= r_sel_lane;
            r_out_word    <= rd_data[WORD_BITS-1:0];
            r_out_chan    <= rd_data[WORD_BITS +: CHANNEL_BITS];
            r_out_last    <= r_sel_last;
        end
    end

    assign o_status.pend_any = (r_pend != '0);
    assign o_status.out_free = out_free;
    assign o_status.sel_last = r_sel_last;

    assign o_out_valid   = r_out_valid;
    assign o_out_outcome = r_out_outcome;
    assign o_out_lane    = r_out_lane;
    assign o_out_word    = r_out_word;
    assign o_out_chan    = r_out_chan;
    assign o_out_last    = r_out_last;

    `SCFB_ASSERT_IMP(a_load_free, i_clk, i_rst_n, out_load, out_free,
        "result loaded over an untaken result")
    `SCFB_ASSERT_IMP(a_pop_pending, i_clk, i_rst_n, i_cmd.pop, nonempty[sel] && (r_pend != '0),
        "pop from a lane with nothing pending")

    for (genvar g = 0; g < LANES; g++) begin : g_cnt_chk
        `SCFB_ASSERT(a_count_max, i_clk, i_rst_n, r_count[g] <= CNT_FULL,
            "lane occupancy above depth")
    end

endmodule

### hw/rtl/send_channel_fifo_bank_core.sv
// Top level of the send channel FIFO bank: stream ports around controller and datapath.
// Depends on scfb_pkg, scfb_ctrl, scfb_datapath (and through it scfb_ram).
//
// Four lanes of LANE_DEPTH-deep FIFOs buffer outgoing words with their destination
// channel. A push transaction (tuser 0) goes to lane dest_channel mod 4, which keeps
// words for one destination in order; if that lane is full the word is dropped and
// the result says so. A flow-control transaction (tuser 1) carries one ready bit per
// lane: lanes are visited from 0 upward and every ready, non-empty lane sends its
// head word, one result each; tlast marks the final one. When no lane sends, a
// single "nothing sent" result comes out. Every transaction yields at least one
// result, and results come in order. A push is accepted in S_IDLE and its result is
// loaded in S_PUSH; a flow update passes S_PICK and S_READ for each word sent (S_PICK
// alone loads the result when nothing is sent), because all entries live in one RAM
// with a single registered read port and each pop is a read followed by a result
// load. Every result load waits while the result register still holds an untaken
// result, so m_axis_tready stalls hold up the sequence. One transaction is in flight
// at a time; the result register lets the next transaction be accepted while the last
// result still waits on m_axis_tready.
// The entry RAM needs no clearing after reset: only written entries are ever read.
module send_channel_fifo_bank_core #(
    parameter int LANE_DEPTH = scfb_pkg::LANE_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [31:0] data_word, [47:32] dest_channel, [51:48] lane_ready_mask, rest zero
    input  logic [scfb_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // [0] req_type
    input  logic                               s_axis_tuser,
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [1:0] lane, [33:2] sent_word, [49:34] sent_channel, rest zero
    output logic [scfb_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // [1:0] outcome
    output logic [1:0]                         m_axis_tuser,
    // last_result
    output logic                               m_axis_tlast
);
    import scfb_pkg::*;

    localparam int OUT_USED = LANE_W + WORD_BITS + CHANNEL_BITS;

    t_scfb_cmd               cmd;
    t_scfb_status            status;
    t_outcome                out_outcome;
    logic [LANE_W-1:0]       out_lane;
    logic [WORD_BITS-1:0]    out_word;
    logic [CHANNEL_BITS-1:0] out_chan;

    scfb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_kind  (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    scfb_datapath #(
        .LANE_DEPTH (LANE_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_in_tdata    (s_axis_tdata),
        .i_out_ready   (m_axis_tready),
        .o_status      (status),
        .o_out_valid   (m_axis_tvalid),
        .o_out_outcome (out_outcome),
        .o_out_lane    (out_lane),
        .o_out_word    (out_word),
        .o_out_chan    (out_chan),
        .o_out_last    (m_axis_tlast)
    );

    assign m_axis_tuser = out_outcome;
    assign m_axis_tdata = {{(OUT_TDATA_W - OUT_USED){1'b0}}, out_chan, out_word, out_lane};

endmodule
